@@ rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");
`endif

@@ rtl/pbf_pkg.sv @@
// Package with constants and types of the PCM byte to float converter.
package pbf_pkg;
  localparam logic [15:0] FMT_PCM = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;
  localparam logic [7:0] BPS_RESET = 8'd16;
  localparam logic CFG_FORMAT = 1'b0;
  localparam logic CFG_BITS = 1'b1;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic [31:0] sample_float;
    logic        unsupported;
  } pbf_result_t;
endpackage

@@ rtl/pbf_stream_if.sv @@
// Valid/ready stream interfaces for input bytes and result words.
interface pbf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  modport source (output valid, output raw_byte, input ready);
  modport sink (input valid, input raw_byte, output ready);
endinterface

interface pbf_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_float;
  logic        unsupported;
  modport source (output valid, output sample_float, output unsupported, input ready);
  modport sink (input valid, input sample_float, input unsupported, output ready);
endinterface

@@ rtl/pcm_bytes_to_float32_converter.sv @@
// One byte is accepted per cycle while ready, and a result word is registered
// in the cycle after the last byte of a sample; the single result register
// sets this rate. Input ready is high whenever it is empty or being read.
module pcm_bytes_to_float32_converter
  import pbf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pbf_byte_if.sink              in,
  pbf_result_if.source          out
);
  logic [15:0] format_code;
  logic [7:0]  bits_per_sample;
  logic [23:0] partial_sample;
  logic [1:0]  byte_position;
  logic        out_valid;
  pbf_result_t result;
  logic        accept, ok, last, emit;
  logic [1:0]  nlast;
  logic [31:0] word, conv;
  logic [23:0] mag;
  logic        sgn;
  logic [7:0]  k;
  logic [4:0]  msb;

  assign in.ready = !out_valid || out.ready;
  assign accept = in.valid && in.ready;
  assign out.valid = out_valid;
  assign out.sample_float = result.sample_float;
  assign out.unsupported = result.unsupported;

  always_comb begin
    ok = 1'b1;
    nlast = 2'd0;
    k = 8'd0;
    if (format_code == FMT_PCM && bits_per_sample == 8'd8) begin
      nlast = 2'd0; k = 8'd7;
    end else if (format_code == FMT_PCM && bits_per_sample == 8'd16) begin
      nlast = 2'd1; k = 8'd15;
    end else if (format_code == FMT_PCM && bits_per_sample == 8'd24) begin
      nlast = 2'd2; k = 8'd23;
    end else if (format_code == FMT_FLOAT && bits_per_sample == 8'd32) begin
      nlast = 2'd3;
    end else begin
      ok = 1'b0;
    end
    last = byte_position >= nlast;
    emit = !ok || last;
    word = {8'd0, partial_sample};
    case (nlast)
      2'd0: word = {24'd0, in.raw_byte};
      2'd1: word[15:8] = in.raw_byte;
      2'd2: word[23:16] = in.raw_byte;
      default: word[31:24] = in.raw_byte;
    endcase
    // Signed magnitude of the integer sample, up to 2^23.
    case (nlast)
      2'd0: begin
        sgn = !word[7];
        mag = sgn ? 24'(8'd128 - word[7:0]) : 24'(word[7:0] - 8'd128);
      end
      2'd1: begin
        sgn = word[15];
        mag = sgn ? 24'(17'h10000 - {1'b0, word[15:0]}) : {8'd0, word[15:0]};
      end
      default: begin
        sgn = word[23];
        mag = sgn ? 24'(25'h1000000 - {1'b0, word[23:0]}) : word[23:0];
      end
    endcase
    msb = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (mag[i]) msb = 5'(i);
    end
    if (nlast == 2'd3) conv = word;
    else if (mag == 24'd0) conv = 32'd0;
    else conv = {sgn, 8'(8'd127 + {3'd0, msb} - k),
                 23'(mag << (5'd23 - msb))};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      format_code <= FMT_PCM;
      bits_per_sample <= BPS_RESET;
      partial_sample <= '0;
      byte_position <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && !out.ready) || (!cfg_we && accept && emit);
      if (cfg_we) begin
        case (cfg_index)
          CFG_FORMAT: format_code <= cfg_data;
          CFG_BITS: bits_per_sample <= cfg_data[7:0];
          default: ;
        endcase
        partial_sample <= '0;
        byte_position <= '0;
      end else if (accept) begin
        if (emit) begin
          result.sample_float <= ok ? conv : 32'd0;
          result.unsupported <= !ok;
          if (ok) begin
            partial_sample <= '0;
            byte_position <= '0;
          end
        end else begin
          case (byte_position)
            2'd0: partial_sample[7:0] <= in.raw_byte;
            2'd1: partial_sample[15:8] <= in.raw_byte;
            default: partial_sample[23:16] <= in.raw_byte;
          endcase
          byte_position <= byte_position + 2'd1;
        end
      end
    end
  end
endmodule

@@ rtl/pbf_checker.sv @@
// Port-level checker for the converter, bound into the converter module.
`include "assert_macros.svh"
module pbf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] sample_float,
  input logic        unsupported
);
  `ASSERT_IMPL(a_unsup_zero, clk, rst, out_valid && unsupported, sample_float == 32'd0)
  `ASSERT_IMPL(a_ready_free, clk, rst, !out_valid, in_ready)
  `ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(sample_float))
  `ASSERT_NEXT(a_no_spurious, clk, rst, !(in_valid && in_ready) && (!out_valid || out_ready),
               !out_valid)
endmodule

bind pcm_bytes_to_float32_converter pbf_checker u_pbf_checker (
  .clk(clk), .rst(rst), .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready),
  .sample_float(out.sample_float), .unsupported(out.unsupported)
);

@@ dv/tb.sv @@
// Testbench of the PCM byte to IEEE single-precision converter.
module tb;
  import pbf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] sample_float;
    logic        unsupported;
  } sample_word_t;

  class sample_scoreboard;
    logic [15:0]  fmt;
    logic [7:0]   bps;
    logic [23:0]  gathered;
    int unsigned  gathered_cnt;
    sample_word_t pending[$];
    int unsigned  errors;

    function new();
      fmt = FMT_PCM;
      bps = BPS_RESET;
      gathered = '0;
      gathered_cnt = 0;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [15:0] data);
      if (idx == CFG_FORMAT) fmt = data;
      else bps = data[7:0];
      gathered = '0;
      gathered_cnt = 0;
    endfunction

    // Exact pattern of v / 2^k; |v| never exceeds 2^23 here.
    function logic [31:0] scaled_float(int v, int k);
      logic [31:0] mag;
      logic        neg;
      int          msb;
      logic [31:0] frac;
      logic [7:0]  expo;
      if (v == 0) return 32'h0;
      neg = v < 0;
      mag = neg ? -v : v;
      msb = 0;
      while ((mag >> msb) > 1) msb++;
      frac = (mag << (23 - msb)) & 32'h007F_FFFF;
      expo = 8'(msb + 127 - k);
      return {neg, expo, frac[22:0]};
    endfunction

    function void note_byte(logic [7:0] b);
      int unsigned  nbytes;
      logic [31:0]  word;
      sample_word_t r;
      if (fmt == FMT_PCM && (bps == 8 || bps == 16 || bps == 24)) nbytes = 32'(bps >> 3);
      else if (fmt == FMT_FLOAT && bps == 32) nbytes = 4;
      else begin
        r.sample_float = '0;
        r.unsupported = 1'b1;
        pending.push_back(r);
        return;
      end
      if (gathered_cnt + 1 < nbytes) begin
        gathered[8*gathered_cnt +: 8] = b;
        gathered_cnt++;
        return;
      end
      word = {8'h00, gathered};
      word[8*(nbytes-1) +: 8] = b;
      case (nbytes)
        1: r.sample_float = scaled_float(int'(word[7:0]) - 128, 7);
        2: r.sample_float = scaled_float(int'($signed(word[15:0])), 15);
        3: r.sample_float = scaled_float(int'($signed(word[23:0])), 23);
        default: r.sample_float = word;
      endcase
      r.unsupported = 1'b0;
      gathered = '0;
      gathered_cnt = 0;
      pending.push_back(r);
    endfunction

    function void check_word(logic [31:0] f, logic u);
      sample_word_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word: sample_float %h unsupported %b", f, u);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (f !== e.sample_float) begin
        $error("sample_float: expected %h, actual %h", e.sample_float, f);
        errors++;
      end
      if (u !== e.unsupported) begin
        $error("unsupported: expected %b, actual %b", e.unsupported, u);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  pbf_byte_if   byte_ch();
  pbf_result_if word_ch();

  sample_scoreboard sb = new();
  bit src_idle_on;
  bit sink_stall_on;
  int unsigned stall_left;

  pcm_bytes_to_float32_converter u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in(byte_ch.sink), .out(word_ch.source)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && byte_ch.valid && byte_ch.ready) sb.note_byte(byte_ch.raw_byte);
    if (!rst && word_ch.valid && word_ch.ready)
      sb.check_word(word_ch.sample_float, word_ch.unsupported);
  end

  // Result sink: stalls for a random time after each word when sink stalls are on.
  always @(posedge clk) begin
    if (rst) begin
      word_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (word_ch.valid && word_ch.ready) begin
      stall_left = sink_stall_on ? $urandom_range(0, 9) : 0;
      word_ch.ready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      word_ch.ready <= (stall_left == 0);
    end else begin
      word_ch.ready <= 1'b1;
    end
  end

  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    gap = src_idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.raw_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
  endtask

  // Registers are only written once all expected words are out.
  task automatic drain();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
  endtask

  task automatic set_mode(logic [15:0] fmt, logic [7:0] bps);
    drain();
    write_reg(CFG_FORMAT, fmt);
    write_reg(CFG_BITS, {8'h00, bps});
    src_idle_on = $urandom_range(0, 3) != 0;
    sink_stall_on = $urandom_range(0, 3) != 0;
  endtask

  task automatic send_random(int unsigned n);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
  endtask

  logic [15:0] mode_fmt[10] = '{FMT_PCM, FMT_PCM, FMT_PCM, FMT_FLOAT, 16'd0,
                                 16'hFFFF, FMT_FLOAT, FMT_PCM, FMT_PCM, FMT_FLOAT};
  logic [7:0]  mode_bps[10] = '{8'd8, 8'd16, 8'd24, 8'd32, 8'd0,
                                 8'hFF, 8'd16, 8'd32, 8'd12, 8'd8};

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    byte_ch.valid = 1'b0;
    byte_ch.raw_byte = '0;
    src_idle_on = 1'b1;
    sink_stall_on = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset mode, 16-bit PCM: zero, both full-scale ends, minus one.
    send_byte(8'h00); send_byte(8'h00);
    send_byte(8'hFF); send_byte(8'h7F);
    send_byte(8'h00); send_byte(8'h80);
    send_byte(8'hFF); send_byte(8'hFF);
    // A half sample is dropped by the register write.
    send_byte(8'h5A);
    set_mode(FMT_PCM, 8'd8);
    send_byte(8'h80); send_byte(8'h00); send_byte(8'hFF); send_byte(8'h81);
    set_mode(FMT_PCM, 8'd24);
    send_byte(8'h00); send_byte(8'h00); send_byte(8'h80);
    send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h7F);
    set_mode(FMT_FLOAT, 8'd32);
    send_byte(8'h78); send_byte(8'h56); send_byte(8'h34); send_byte(8'h12);
    set_mode(16'hFFFF, 8'hFF);
    send_byte(8'hAA); send_byte(8'h55);

    for (int p = 0; p < 16; p++) begin
      int k;
      k = $urandom_range(0, 9);
      if (p < 10) k = p;
      if (p == 15) set_mode(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      else set_mode(mode_fmt[k], mode_bps[k]);
      send_random($urandom_range(60, 100));
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
